[rtl/gffr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffr_pkg
// shared widths and constants for the grid reachability block
// ----------------------------------------------------------------------------
package gffr_pkg;
    localparam int GridSizeDefault = 32;
    localparam int RowW = 32;
    localparam int RowIdxW = 5;
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 4;
    localparam logic [CfgIdxW-1:0] CfgConnectSides = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgPageAllSolid = 1'd1;

    typedef struct packed {
        logic [RowW-1:0]    open_mask;
        logic               last_row;
    } t_in_beat;

    typedef struct packed {
        logic [RowW-1:0]    reach_mask;
        logic [RowIdxW-1:0] row_number;
        logic               last_result;
    } t_out_beat;
endpackage

[rtl/gffr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffr_if
// valid/ready channel carrying one packed beat
// ----------------------------------------------------------------------------
interface gffr_if #(
    parameter int W = 33
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/grid_flood_fill_reach.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_flood_fill_reach
// 8-connected flood fill over a row-loaded grid, one reach mask per row out
// ----------------------------------------------------------------------------
// a row beat is accepted while ready is high; ready stays low from a last row until emit ends
// fill: sweeps over all rows, one row per cycle through a single row-dilation
// unit, until a whole sweep changes nothing; every extra sweep marks a new cell,
// so the fill ends once no new cell is left to mark; no fill when all-solid
// then SIDE result beats follow, one per cycle when the sink is ready
// reset clears control state, config registers and the reach store, not the open store
module grid_flood_fill_reach
    import gffr_pkg::*;
#(
    parameter int GRID_SIZE = GridSizeDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    gffr_if.sink                in_ch,
    gffr_if.source              out_ch
);
    localparam int Side = (GRID_SIZE > 32) ? 32 : GRID_SIZE;
    localparam int Half = Side / 2;
    localparam int Edge = Side - 1;
    localparam logic [RowW-1:0] RowMask = RowW'((64'd1 << Side) - 64'd1);

    typedef enum logic [1:0] {S_LOAD, S_FILL, S_EMIT} t_state;

    t_state               r_state;
    logic [RowW-1:0]      r_open [32];
    logic [RowW-1:0]      r_reach [32];
    logic [RowIdxW-1:0]   r_row;
    logic [RowIdxW-1:0]   r_y;
    logic                 r_changed;
    logic [3:0]           r_sides;
    logic                 r_solid;

    t_in_beat             w_in;
    t_out_beat            w_out;
    logic [RowW-1:0]      w_up, w_mid, w_dn, w_nb, w_new;
    logic [RowIdxW-1:0]   w_sy;
    logic [RowW-1:0]      w_sx;

    assign w_in = in_ch.data;
    assign in_ch.ready = (r_state == S_LOAD);
    assign out_ch.valid = (r_state == S_EMIT);
    assign w_out.reach_mask = r_reach[r_y] & RowMask;
    assign w_out.row_number = r_y;
    assign w_out.last_result = (r_y == RowIdxW'(Edge));
    assign out_ch.data = w_out;

    // start cell by priority
    always_comb begin
        if (r_sides[0]) begin
            w_sy = RowIdxW'(Half); w_sx = RowW'(1);
        end else if (r_sides[1]) begin
            w_sy = RowIdxW'(Half); w_sx = RowW'(1) << Edge;
        end else if (r_sides[2]) begin
            w_sy = '0; w_sx = RowW'(1) << Half;
        end else begin
            w_sy = RowIdxW'(Edge); w_sx = RowW'(1) << Half;
        end
    end

    // shared row dilation unit
    always_comb begin
        w_mid = r_reach[r_y];
        w_up = (r_y == '0) ? '0 : r_reach[r_y - 1'b1];
        w_dn = (r_y == RowIdxW'(Edge)) ? '0 : r_reach[r_y + 1'b1];
        w_nb = w_up | w_mid | w_dn;
        w_nb = w_nb | (w_nb << 1) | (w_nb >> 1);
        w_new = w_mid | (w_nb & r_open[r_y] & RowMask);
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready)
            r_open[r_row] <= w_in.open_mask & RowMask;
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_row <= '0;
            r_y <= '0;
            r_changed <= 1'b0;
            r_sides <= '0;
            r_solid <= 1'b0;
            for (int i = 0; i < 32; i++) r_reach[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgConnectSides: r_sides <= i_cfg_data;
                    CfgPageAllSolid: r_solid <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_LOAD: begin
                    if (in_ch.valid) begin
                        // first row clears the store, last row seeds the start cell unless all-solid
                        for (int i = 0; i < 32; i++) begin
                            if (w_in.last_row && !r_solid && (RowIdxW'(i) == w_sy))
                                r_reach[i] <= ((r_row == '0) ? '0 : r_reach[i]) | w_sx;
                            else if (r_row == '0)
                                r_reach[i] <= '0;
                        end
                        if (w_in.last_row) begin
                            r_row <= '0;
                            r_y <= '0;
                            r_changed <= 1'b0;
                            if (r_solid) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_FILL;
                            end
                        end else begin
                            r_row <= (r_row == RowIdxW'(Edge)) ? '0 : r_row + 1'b1;
                        end
                    end
                end
                S_FILL: begin
                    r_reach[r_y] <= w_new;
                    if (r_y == RowIdxW'(Edge)) begin
                        r_y <= '0;
                        r_changed <= 1'b0;
                        if (!(r_changed || w_new != w_mid)) r_state <= S_EMIT;
                    end else begin
                        r_y <= r_y + 1'b1;
                        if (w_new != w_mid) r_changed <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_ch.ready) begin
                        if (r_y == RowIdxW'(Edge)) begin
                            r_y <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_y <= r_y + 1'b1;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

[dv/grid_reach_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_reach_scoreboard
// keeps a copy of the grid and reach state, predicts the per-row reach masks
// of each frame and checks the beats that come out of the block
// ----------------------------------------------------------------------------
class grid_reach_scoreboard;
    int side;
    logic [31:0] open_rows [32];
    logic [31:0] reach_rows [32];
    int rows_in;
    logic [3:0] sides;
    bit all_solid;
    gffr_pkg::t_out_beat pending_rows [$];
    int errors;

    function new(int grid_side);
        side = grid_side;
        rows_in = 0;
        sides = 4'd0;
        all_solid = 1'b0;
        errors = 0;
        for (int i = 0; i < 32; i++) begin
            open_rows[i] = '0;
            reach_rows[i] = '0;
        end
    endfunction

    function logic [31:0] row_mask();
        return (side >= 32) ? 32'hffff_ffff : ((32'd1 << side) - 32'd1);
    endfunction

    function void flood();
        int cx;
        int cy;
        int qx [$];
        int qy [$];
        int px;
        int py;
        int nx;
        int ny;
        if (sides[0]) begin
            cx = 0; cy = side / 2;
        end else if (sides[1]) begin
            cx = side - 1; cy = side / 2;
        end else if (sides[2]) begin
            cx = side / 2; cy = 0;
        end else begin
            cx = side / 2; cy = side - 1;
        end
        reach_rows[cy][cx] = 1'b1;
        qx.insert(qx.size(), cx);
        qy.insert(qy.size(), cy);
        while (qx.size() > 0) begin
            px = qx.pop_front();
            py = qy.pop_front();
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    nx = px + dx;
                    ny = py + dy;
                    if ((dx != 0 || dy != 0) && nx >= 0 && nx < side && ny >= 0 &&
                        ny < side) begin
                        if (open_rows[ny][nx] && !reach_rows[ny][nx]) begin
                            reach_rows[ny][nx] = 1'b1;
                            qx.insert(qx.size(), nx);
                            qy.insert(qy.size(), ny);
                        end
                    end
                end
            end
        end
    endfunction

    function void note_row(gffr_pkg::t_in_beat b);
        gffr_pkg::t_out_beat r;
        int row;
        row = (rows_in >= side) ? 0 : rows_in;
        if (row == 0) begin
            for (int i = 0; i < 32; i++) reach_rows[i] = '0;
        end
        open_rows[row] = b.open_mask & row_mask();
        rows_in = (row + 1 >= side) ? 0 : row + 1;
        if (b.last_row) begin
            if (!all_solid) flood();
            rows_in = 0;
            for (int y = 0; y < side; y++) begin
                r.reach_mask = reach_rows[y] & row_mask();
                r.row_number = y[4:0];
                r.last_result = (y == side - 1);
                pending_rows.insert(pending_rows.size(), r);
            end
        end
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_row(gffr_pkg::t_out_beat got);
        gffr_pkg::t_out_beat want;
        if (pending_rows.size() == 0) begin
            report($sformatf("unexpected beat row %0d", got.row_number));
            return;
        end
        want = pending_rows.pop_front();
        if (got.reach_mask !== want.reach_mask)
            report($sformatf("row %0d reach %h want %h", want.row_number,
                got.reach_mask, want.reach_mask));
        if (got.row_number !== want.row_number)
            report($sformatf("row_number %0d want %0d", got.row_number, want.row_number));
        if (got.last_result !== want.last_result)
            report($sformatf("row %0d last_result %b want %b", want.row_number,
                got.last_result, want.last_result));
    endtask
endclass

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives whole grids and broken frames into the reachability block under
// several start-side and all-solid settings, with random source gaps and
// sink stalls, and checks every reach beat against a flood-fill predictor
// ----------------------------------------------------------------------------
module testbench;
    import gffr_pkg::*;

    localparam int Side = GridSizeDefault;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    int src_idle;
    int snk_stall;

    gffr_if #(.W($bits(t_in_beat))) in_ch ();
    gffr_if #(.W($bits(t_out_beat))) out_ch ();

    grid_reach_scoreboard sb;

    grid_flood_fill_reach #(.GRID_SIZE(Side)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // sink side: random stalls, check on accept
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_row(t_out_beat'(out_ch.data));
        out_ch.ready <= ($urandom_range(99) >= snk_stall);
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgConnectSides) sb.sides = val;
        else sb.all_solid = val[0];
        @(posedge i_clk);
    endtask

    task automatic send_row(logic [31:0] mask, logic last);
        t_in_beat b;
        b.open_mask = mask;
        b.last_row = last;
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_row(b);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_rows.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_row(int density);
        logic [31:0] m;
        for (int i = 0; i < 32; i++) m[i] = ($urandom_range(99) < density);
        return m;
    endfunction

    task automatic send_grid(int density, int rows);
        for (int y = 0; y < rows; y++) send_row(rand_row(density), y == rows - 1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CfgConnectSides;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        src_idle = 0;
        snk_stall = 0;
        sb = new(Side);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all open, all solid (solid start), then the all-solid page setting
        write_reg(CfgConnectSides, 4'd0);
        write_reg(CfgPageAllSolid, 4'd0);
        for (int y = 0; y < Side; y++) send_row(32'hffff_ffff, y == Side - 1);
        drain();
        write_reg(CfgConnectSides, 4'hf);
        for (int y = 0; y < Side; y++) send_row(32'h0000_0000, y == Side - 1);
        drain();
        write_reg(CfgPageAllSolid, 4'd1);
        for (int y = 0; y < Side; y++) send_row(32'hffff_ffff, y == Side - 1);
        drain();
        write_reg(CfgPageAllSolid, 4'd0);
        // short frame keeps earlier rows; overlong frame wraps
        write_reg(CfgConnectSides, 4'd2);
        send_grid(60, 3);
        drain();
        write_reg(CfgConnectSides, 4'd4);
        for (int y = 0; y < Side + 2; y++) send_row(rand_row(70), y == Side + 1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            src_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 58 : 24) : 0;
            snk_stall = (ph == 2) ? 58 : ((ph == 3) ? 24 : 0);
            for (int g = 0; g < 2; g++) begin
                write_reg(CfgConnectSides, 4'($urandom_range(15)));
                write_reg(CfgPageAllSolid, CfgDataW'($urandom_range(9) == 0));
                if (g == 1) send_grid($urandom_range(100), $urandom_range(1, 8));
                else send_grid($urandom_range(40, 95), Side);
                drain();
            end
        end
        if (sb.errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
